[hw/rtl/jbs_pkg.sv]
// Package for the J1939 BAM frame segmenter.
// Holds transport-protocol constants, register indexes, frame kind codes and
// the identifier builder. No dependencies.
package jbs_pkg;

    // Transport protocol constants
    localparam logic [17:0] TP_CM_PGN   = 18'h00EC00;
    localparam logic [17:0] TP_DT_PGN   = 18'h00EB00;
    localparam logic [7:0]  GLOBAL_ADDR = 8'hFF;
    localparam logic [7:0]  BAM_CONTROL = 8'd32;
    localparam logic [7:0]  FILL_BYTE   = 8'hFF;
    localparam logic [2:0]  DT_LAST_SLOT = 3'd6;   // 7 data bytes per packet
    localparam logic [7:0]  PDU2_START  = 8'd240;
    localparam int unsigned DT_BYTES    = 7;

    // ceil(len/7) via reciprocal: (len + 6) * RECIP7 >> RECIP7_SHIFT
    localparam logic [11:0] RECIP7       = 12'd2341;
    localparam int unsigned RECIP7_SHIFT = 14;

    // Configuration register indexes
    localparam logic [7:0] CFG_PRIORITY = 8'd0;
    localparam logic [7:0] CFG_PGN      = 8'd1;
    localparam logic [7:0] CFG_DEST     = 8'd2;
    localparam logic [7:0] CFG_SOURCE   = 8'd3;

    // Frame kind codes
    typedef enum logic [1:0] {
        KIND_SINGLE   = 2'd0,
        KIND_ANNOUNCE = 2'd1,
        KIND_DATA     = 2'd2
    } t_frame_kind;

    // 29-bit J1939 identifier; extended data page (PGN bit 17) is dropped
    function automatic logic [28:0] make_id(
        input logic [2:0]  prio,
        input logic [17:0] pgn,
        input logic [7:0]  dest,
        input logic [7:0]  src
    );
        logic [7:0] pf;
        logic [7:0] ps;
        pf = pgn[15:8];
        ps = (pf < PDU2_START) ? dest : pgn[7:0];
        return {prio, 1'b0, pgn[16], pf, ps, src};
    endfunction

endpackage

[hw/rtl/j1939_bam_frame_segmenter_core.sv]
// Top level of the J1939 BAM frame segmenter: byte gathering, frame
// building and the output register. Depends on jbs_pkg.
//
//  Channel  | Direction | Signals                                | Content
//  ---------+-----------+----------------------------------------+---------------------------
//  s (in)   | slave     | i_s_tvalid o_s_tready i_s_tdata        | payload byte, message length
//  m (out)  | master    | o_m_tvalid i_m_tready o_m_tdata/tuser/tlast | one CAN frame
//  cfg      | slave     | i_cfg_valid o_cfg_ready i_cfg_index/data | register writes
//
// One byte is taken per cycle unless the input stalls; each byte yields at most one frame, built by
// a single layer of logic from the byte, the message state and the registers,
// and registered in the output register as the byte is taken.
// The input stalls only while a finished frame waits and i_m_tready is low.
// Synchronous active-low reset clears the message state, the output valid
// and restores the register defaults. Configuration is always ready.
module j1939_bam_frame_segmenter_core #(
    parameter int unsigned MAX_PACKETS = 255
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [23:0]  i_s_tdata,   // [7:0] payload_byte, [23:8] message_length
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // [28:0] frame_id, [32:29] frame_len,
                                      // [96:33] frame_data, zero above
    output logic [2:0]   o_m_tuser,   // [1:0] frame_kind, [2] length_error
    output logic         o_m_tlast,   // last_frame
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [17:0]  i_cfg_data
);

    localparam int unsigned DT_BYTES_X = jbs_pkg::DT_BYTES;
    localparam logic [16:0] MAX_LEN = 17'(DT_BYTES_X * MAX_PACKETS);

    // Configuration registers
    logic [2:0]  r_prio;
    logic [17:0] r_pgn;
    logic [7:0]  r_dest;
    logic [7:0]  r_src;

    // Message state
    logic [15:0] r_bytes;      // bytes taken of current message
    logic [2:0]  r_mod7;       // r_bytes mod 7
    logic [7:0]  r_pkt_num;
    logic [63:0] r_gather;
    logic        r_swallow;

    logic [15:0] n_bytes;
    logic [2:0]  n_mod7;
    logic [7:0]  n_pkt_num;
    logic [63:0] n_gather;
    logic        n_swallow;

    // Output register
    logic        r_out_valid;
    logic [28:0] r_id;
    logic [3:0]  r_flen;
    logic [63:0] r_fdata;
    jbs_pkg::t_frame_kind r_kind;
    logic        r_last;
    logic        r_err;

    logic        n_emit;
    logic [28:0] n_id;
    logic [3:0]  n_flen;
    logic [63:0] n_fdata;
    jbs_pkg::t_frame_kind n_kind;
    logic        n_last;
    logic        n_err;

    // Datapath helpers
    logic        s_acc;
    logic [7:0]  in_byte;
    logic [15:0] in_len;
    logic [16:0] cnt_next;
    logic        msg_done;
    logic        len_err;
    logic [11:0] pk_x;
    logic [23:0] pk_prod;
    logic [7:0]  packets;
    logic [63:0] g_single;
    logic [63:0] g_bam;
    logic [63:0] g_base;
    logic [63:0] dt_data;
    logic [63:0] sf_data;
    logic [2:0]  mod7_inc;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign in_byte     = i_s_tdata[7:0];
    assign in_len      = i_s_tdata[23:8];

    // Configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= 3'd6;
            r_pgn  <= '0;
            r_dest <= 8'hFF;
            r_src  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jbs_pkg::CFG_PRIORITY: r_prio <= i_cfg_data[2:0];
                jbs_pkg::CFG_PGN:      r_pgn  <= i_cfg_data;
                jbs_pkg::CFG_DEST:     r_dest <= i_cfg_data[7:0];
                jbs_pkg::CFG_SOURCE:   r_src  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Counters, length checks, packet count
    always_comb begin
        cnt_next = {1'b0, r_bytes} + 17'd1;
        msg_done = cnt_next >= {1'b0, in_len};
        len_err  = (in_len == 16'd0) ||
                   ((in_len > 16'd8) && ({1'b0, in_len} > MAX_LEN));
        pk_x     = {1'b0, in_len[10:0]} + 12'd6;
        pk_prod  = 24'(pk_x) * 24'(jbs_pkg::RECIP7);
        packets  = pk_prod[jbs_pkg::RECIP7_SHIFT +: 8];
        mod7_inc = (r_mod7 == jbs_pkg::DT_LAST_SLOT) ? 3'd0 : r_mod7 + 3'd1;
    end

    // Byte insertion and frame payload assembly
    always_comb begin
        g_single = r_gather;
        g_single[8*r_bytes[2:0] +: 8] = in_byte;

        g_base = (r_bytes == 16'd0) ? 64'd0 : r_gather;
        g_bam  = g_base;
        g_bam[8*r_mod7 +: 8] = in_byte;

        dt_data = {56'd0, r_pkt_num + 8'd1};
        for (int i = 0; i < 7; i++) begin
            dt_data[8*(i+1) +: 8] = (3'(i) <= r_mod7) ? g_bam[8*i +: 8]
                                                      : jbs_pkg::FILL_BYTE;
        end

        sf_data = g_single;
        for (int i = 0; i < 8; i++) begin
            if ((4'(i) >= in_len[3:0]) && (in_len[3:0] < 4'd8)) begin
                sf_data[8*i +: 8] = 8'd0;
            end
        end
    end

    // Per-byte decision: next state and the frame it yields
    always_comb begin
        n_bytes   = r_bytes;
        n_mod7    = r_mod7;
        n_pkt_num = r_pkt_num;
        n_gather  = r_gather;
        n_swallow = r_swallow;
        n_emit    = 1'b0;
        n_id      = '0;
        n_flen    = '0;
        n_fdata   = '0;
        n_kind    = jbs_pkg::KIND_SINGLE;
        n_last    = 1'b0;
        n_err     = 1'b0;

        if (r_swallow) begin
            // rest of a bad message: count it off silently
            if (msg_done) begin
                n_bytes = '0; n_mod7 = '0; n_pkt_num = '0;
                n_gather = '0; n_swallow = 1'b0;
            end else begin
                n_bytes = cnt_next[15:0];
                n_mod7  = mod7_inc;
            end
        end else if (len_err) begin
            n_emit = 1'b1;
            n_err  = 1'b1;
            n_pkt_num = '0;
            n_gather  = '0;
            if ((in_len == 16'd0) || msg_done) begin
                n_bytes = '0; n_mod7 = '0; n_swallow = 1'b0;
            end else begin
                n_bytes   = cnt_next[15:0];
                n_mod7    = mod7_inc;
                n_swallow = 1'b1;
            end
        end else if (in_len <= 16'd8) begin
            // single frame
            if (msg_done) begin
                n_emit  = 1'b1;
                n_id    = jbs_pkg::make_id(r_prio, r_pgn, r_dest, r_src);
                n_flen  = in_len[3:0];
                n_fdata = sf_data;
                n_kind  = jbs_pkg::KIND_SINGLE;
                n_last  = 1'b1;
                n_bytes = '0; n_mod7 = '0; n_pkt_num = '0;
                n_gather = '0;
            end else begin
                n_gather = g_single;
                n_bytes  = cnt_next[15:0];
                n_mod7   = mod7_inc;
            end
        end else begin
            // BAM transfer
            n_gather = g_bam;
            if (r_bytes == 16'd0) begin
                n_emit  = 1'b1;
                n_id    = jbs_pkg::make_id(r_prio, jbs_pkg::TP_CM_PGN,
                                           jbs_pkg::GLOBAL_ADDR, r_src);
                n_flen  = 4'd8;
                n_fdata = {6'd0, r_pgn[17:16], r_pgn[15:8], r_pgn[7:0],
                           jbs_pkg::FILL_BYTE, packets, in_len[15:8],
                           in_len[7:0], jbs_pkg::BAM_CONTROL};
                n_kind  = jbs_pkg::KIND_ANNOUNCE;
                n_pkt_num = '0;
            end else if ((r_mod7 == jbs_pkg::DT_LAST_SLOT) || msg_done) begin
                n_emit  = 1'b1;
                n_id    = jbs_pkg::make_id(r_prio, jbs_pkg::TP_DT_PGN,
                                           jbs_pkg::GLOBAL_ADDR, r_src);
                n_flen  = 4'd8;
                n_fdata = dt_data;
                n_kind  = jbs_pkg::KIND_DATA;
                n_last  = msg_done;
                n_pkt_num = r_pkt_num + 8'd1;
                n_gather  = '0;
            end
            if (msg_done) begin
                n_bytes = '0; n_mod7 = '0; n_pkt_num = '0; n_gather = '0;
            end else begin
                n_bytes = cnt_next[15:0];
                n_mod7  = mod7_inc;
            end
        end
    end

    // Message state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes   <= '0;
            r_mod7    <= '0;
            r_pkt_num <= '0;
            r_gather  <= '0;
            r_swallow <= 1'b0;
        end else if (s_acc) begin
            r_bytes   <= n_bytes;
            r_mod7    <= n_mod7;
            r_pkt_num <= n_pkt_num;
            r_gather  <= n_gather;
            r_swallow <= n_swallow;
        end
    end

    // Output register: valid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc) begin
            r_out_valid <= n_emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: frame payload
    always_ff @(posedge i_clk) begin
        if (s_acc && n_emit) begin
            r_id    <= n_id;
            r_flen  <= n_flen;
            r_fdata <= n_fdata;
            r_kind  <= n_kind;
            r_last  <= n_last;
            r_err   <= n_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_fdata, r_flen, r_id};
    assign o_m_tuser  = {r_err, r_kind};
    assign o_m_tlast  = r_last;

    // Checks
    a_mod7_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod7 <= jbs_pkg::DT_LAST_SLOT)
        else $error("slot counter out of range");

    a_mod7_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes == 16'd0) |-> (r_mod7 == 3'd0))
        else $error("slot counter not cleared with byte count");

    a_swallow_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_swallow) |=> !o_m_tvalid)
        else $error("frame produced for a swallowed byte");

    a_swallow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_swallow |-> ((r_pkt_num == 8'd0) && (r_gather == 64'd0)))
        else $error("swallowed message left packet state behind");

    a_err_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_err) |-> ((o_m_tdata == 104'd0) && !r_last &&
                                    (r_kind == jbs_pkg::KIND_SINGLE)))
        else $error("error result carries frame content");

endmodule
